// File: rtl/cmi_pkg.sv
package cmi_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int unsigned VAL_W    = 32;
  localparam int unsigned COL_W    = 32;
  localparam int unsigned RAM_W    = VAL_W + COL_W;
  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned CH_W     = $clog2(NUM_CH);

  // shared divider: 8 quotient bits, dividend is a 32-bit value times an 8-bit factor
  localparam int unsigned QUOT_W    = 8;
  localparam int unsigned DIV_STEPS = QUOT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int unsigned PROD_W    = VAL_W + QUOT_W;

  localparam logic [COL_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;
  localparam logic [7:0]       GRAY_FULL    = 8'd255;

  localparam int unsigned    PADDR_W       = 3;
  localparam logic [31:0]    RAMP_MIN_RST  = 32'h0000_0000;
  localparam logic [31:0]    RAMP_MAX_RST  = 32'h00FF_0000;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_CONVERT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_e;

  // register index as decoded from paddr bit 2
  typedef enum logic {
    REG_RAMP_MIN = 1'b0,
    REG_RAMP_MAX = 1'b1
  } reg_e;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [31:0] sample_value;
    logic signed [31:0] entry_value;
    logic        [31:0] entry_color;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [VAL_W-1:0]  num;
    logic [QUOT_W-1:0] mult;
    logic [VAL_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic              rem_nz;
  } div_rsp_t;

endpackage

// File: rtl/cmi_ram.sv
module cmi_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/cmi_div.sv
module cmi_div import cmi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0]    rem_q, dsh_q;
  logic [QUOT_W-1:0]    quot_q;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] dsh_init;
  logic              ge;

  assign prod     = req_i.num * req_i.mult;
  assign dsh_init = PROD_W'(req_i.den) << (DIV_STEPS - 1);
  assign ge       = rem_q >= dsh_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // restoring division, one quotient bit per cycle, MSB first
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= prod;
      dsh_q  <= dsh_init;
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[QUOT_W-2:0], ge};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quot_q;
  assign rsp_o.rem_nz = |rem_q;

endmodule

// File: rtl/colormap_interpolator.sv
// Colour ramp lookup for Q16.16 raster samples; results are ARGB with alpha in bits 31:24.
// Every command gives exactly one result transfer. Clear and append go straight to the
// output state. A conversion with an empty map follows the gray ramp set by
// ramp_min/ramp_max, using the divider only for samples strictly inside the ramp; with
// one entry it returns that entry's colour. Otherwise the map is scanned one segment per
// cycle out of the entry RAM, ending with ST_NOMATCH status when no segment matches. A
// match is then interpolated channel by channel through one shared 8-step divider with
// a 32x8 pre-multiply; a segment with two equal breakpoints takes the lower colour
// without the divider.
// One command is in flight at a time; in_ready_o is low while it is worked on, though a new
// command can be taken while the previous result waits in the output register.
module colormap_interpolator import cmi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_GRAY     = 10'b00_0000_0010,
    S_GRAY_CMP = 10'b00_0000_0100,
    S_GRAY_DIV = 10'b00_0000_1000,
    S_FIRST    = 10'b00_0001_0000,
    S_PRIME    = 10'b00_0010_0000,
    S_SCAN     = 10'b00_0100_0000,
    S_CH_SETUP = 10'b00_1000_0000,
    S_CH_WAIT  = 10'b01_0000_0000,
    S_OUT      = 10'b10_0000_0000
  } state_e;

  state_e                   state_q, state_d;
  in_item_t                 item_q, item_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [CH_W-1:0]          ch_q, ch_d;
  logic signed [VAL_W-1:0]  lo_val_q, lo_val_d;
  logic [COL_W-1:0]         lo_col_q, lo_col_d;
  logic [COL_W-1:0]         hi_col_q, hi_col_d;
  logic signed [VAL_W:0]    num_q, num_d;
  logic signed [VAL_W:0]    den_q, den_d;
  logic [COL_W-1:0]         pix_q, pix_d;
  out_item_t                res_q, res_d;
  out_item_t                out_q;
  logic                     out_valid_q;
  logic [31:0]              ramp_min_q, ramp_max_q;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_raddr;
  logic [RAM_W-1:0]         ram_wdata;
  logic [RAM_W-1:0]         ram_rdata;
  logic signed [VAL_W-1:0]  rd_val;
  logic [COL_W-1:0]         rd_col;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  logic                     accept;
  logic                     out_load;
  logic                     cfg_we;
  logic signed [VAL_W:0]    sv33, lo33, rd33, min33, max33, gnum, gden;
  logic [7:0]               c1, c2, mag, lerp_byte;
  logic [8:0]               d9, dmag9;
  logic                     dneg;

  function automatic logic [COL_W-1:0] gray_px(input logic [7:0] g);
    gray_px = OPAQUE_BLACK | {8'h00, g, g, g};
  endfunction

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = (reg_e'(paddr[2]) == REG_RAMP_MAX) ? ramp_max_q : ramp_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_min_q <= RAMP_MIN_RST;
      ramp_max_q <= RAMP_MAX_RST;
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[2]))
        REG_RAMP_MIN: ramp_min_q <= pwdata;
        REG_RAMP_MAX: ramp_max_q <= pwdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- entry store
  assign ram_wdata = {in_data_i.entry_value, in_data_i.entry_color};
  assign rd_val    = $signed(ram_rdata[RAM_W-1:COL_W]);
  assign rd_col    = ram_rdata[COL_W-1:0];

  cmi_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cmi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- datapath helpers
  assign sv33  = $signed({item_q.sample_value[VAL_W-1], item_q.sample_value});
  assign lo33  = $signed({lo_val_q[VAL_W-1], lo_val_q});
  assign rd33  = $signed({rd_val[VAL_W-1], rd_val});
  assign min33 = $signed({ramp_min_q[VAL_W-1], ramp_min_q});
  assign max33 = $signed({ramp_max_q[VAL_W-1], ramp_max_q});
  assign gnum  = sv33 - min33;
  assign gden  = max33 - min33;

  assign c1    = lo_col_q[{ch_q, 3'b000} +: 8];
  assign c2    = hi_col_q[{ch_q, 3'b000} +: 8];
  assign d9    = {1'b0, c2} - {1'b0, c1};
  assign dneg  = d9[8];
  assign dmag9 = dneg ? (~d9 + 9'd1) : d9;
  assign mag   = dmag9[7:0];
  // floor division: a negative step rounds away from c1 when the remainder is non-zero
  assign lerp_byte = dneg ? (c1 - div_rsp.quot - {7'b0, div_rsp.rem_nz})
                          : (c1 + div_rsp.quot);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign out_load   = (state_q == S_OUT) & (~out_valid_q | out_ready_i);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    ch_d      = ch_q;
    lo_val_d  = lo_val_q;
    lo_col_d  = lo_col_q;
    hi_col_d  = hi_col_q;
    num_d     = num_q;
    den_d     = den_q;
    pix_d     = pix_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_raddr = '0;
    div_req   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          res_d   = '{pixel_color: '0, status: ST_OK};
          state_d = S_OUT;
          unique case (cmd_e'(in_data_i.cmd))
            CMD_CLEAR: cnt_d = '0;
            CMD_APPEND: begin
              if (cnt_q == CNT_W'(MAX_ENTRIES)) begin
                res_d.status = ST_FULL;
              end else begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
              end
            end
            CMD_CONVERT: state_d = (cnt_q == '0) ? S_GRAY : S_FIRST;
            default: ;
          endcase
        end
      end

      S_GRAY: begin
        if (gden < 0) begin
          num_d = -gnum;
          den_d = -gden;
        end else begin
          num_d = gnum;
          den_d = gden;
        end
        state_d = S_GRAY_CMP;
      end

      S_GRAY_CMP: begin
        state_d = S_OUT;
        res_d.status = ST_OK;
        if (den_q == '0) begin
          res_d.pixel_color = gray_px((num_q < 0) ? 8'd0 : GRAY_FULL);
        end else if (num_q <= 0) begin
          res_d.pixel_color = gray_px(8'd0);
        end else if (num_q >= den_q) begin
          res_d.pixel_color = gray_px(GRAY_FULL);
        end else begin
          div_req.start = 1'b1;
          div_req.num   = num_q[VAL_W-1:0];
          div_req.mult  = GRAY_FULL;
          div_req.den   = den_q[VAL_W-1:0];
          state_d       = S_GRAY_DIV;
        end
      end

      S_GRAY_DIV: begin
        if (div_rsp.done) begin
          res_d   = '{pixel_color: gray_px(div_rsp.quot), status: ST_OK};
          state_d = S_OUT;
        end
      end

      S_FIRST: begin
        ram_raddr = '0;
        state_d   = S_PRIME;
      end

      S_PRIME: begin
        lo_val_d = rd_val;
        lo_col_d = rd_col;
        if (cnt_q == CNT_W'(1)) begin
          res_d   = '{pixel_color: rd_col, status: ST_OK};
          state_d = S_OUT;
        end else begin
          ram_raddr = IDX_W'(1);
          idx_d     = IDX_W'(1);
          state_d   = S_SCAN;
        end
      end

      S_SCAN: begin
        // read data holds entry idx_q, lo registers hold entry idx_q-1
        if (item_q.sample_value >= lo_val_q && item_q.sample_value <= rd_val) begin
          num_d    = sv33 - lo33;
          den_d    = rd33 - lo33;
          hi_col_d = rd_col;
          ch_d     = '0;
          state_d  = S_CH_SETUP;
        end else if (CNT_W'(idx_q) + 1'b1 == cnt_q) begin
          res_d   = '{pixel_color: OPAQUE_BLACK, status: ST_NOMATCH};
          state_d = S_OUT;
        end else begin
          lo_val_d  = rd_val;
          lo_col_d  = rd_col;
          idx_d     = idx_q + 1'b1;
          ram_raddr = idx_q + 1'b1;
        end
      end

      S_CH_SETUP: begin
        if (den_q == '0) begin
          pix_d[{ch_q, 3'b000} +: 8] = c1;
          if (ch_q == CH_W'(NUM_CH - 1)) begin
            res_d   = '{pixel_color: pix_d, status: ST_OK};
            state_d = S_OUT;
          end else begin
            ch_d = ch_q + 1'b1;
          end
        end else begin
          div_req.start = 1'b1;
          div_req.num   = num_q[VAL_W-1:0];
          div_req.mult  = mag;
          div_req.den   = den_q[VAL_W-1:0];
          state_d       = S_CH_WAIT;
        end
      end

      S_CH_WAIT: begin
        if (div_rsp.done) begin
          pix_d[{ch_q, 3'b000} +: 8] = lerp_byte;
          if (ch_q == CH_W'(NUM_CH - 1)) begin
            res_d   = '{pixel_color: pix_d, status: ST_OK};
            state_d = S_OUT;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = S_CH_SETUP;
          end
        end
      end

      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    idx_q    <= idx_d;
    ch_q     <= ch_d;
    lo_val_q <= lo_val_d;
    lo_col_q <= lo_col_d;
    hi_col_q <= hi_col_d;
    num_q    <= num_d;
    den_q    <= den_d;
    pix_q    <= pix_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("block still ready after taking a command");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond map size");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_GRAY_DIV || state_q == S_CH_WAIT))
    else $error("divider result with nobody waiting");

endmodule

// File: verif/tb_colormap_interpolator.sv
module tb_colormap_interpolator;
  timeunit 1ns;
  timeprecision 1ps;
  import cmi_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 80;
  localparam int unsigned PHASE_ITEMS = 105;
  localparam int unsigned NUM_PHASES  = 7;

  typedef struct {
    in_item_t    item;
    int unsigned reps;
    bit          fixed;
    out_item_t   res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // typed-in result travelling alongside the item on the input channel
  bit                 fixed_valid = 1'b0;
  out_item_t          fixed_res = '0;

  // predictor state
  logic signed [31:0] ramp_lo = RAMP_MIN_RST;
  logic signed [31:0] ramp_hi = RAMP_MAX_RST;
  int unsigned        map_len = 0;
  logic signed [31:0] map_val [MAX_ENTRIES];
  logic [31:0]        map_col [MAX_ENTRIES];

  out_item_t          pending_px [$];
  dir_row_t           dir_tab [$];
  int unsigned        errors = 0;
  int unsigned        sent_cnt = 0;
  int unsigned        gap_pct = 0;
  int unsigned        cycle_cnt = 0;
  bit                 calm = 1'b0;
  bit                 hold_off_req = 1'b0;

  colormap_interpolator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk = ~clk;

  // Colour lookup for one command; updates the map as the block would.
  function automatic out_item_t ramp_lookup(in_item_t it);
    out_item_t          res;
    logic signed [31:0] v;
    longint             num, den, prod, q, c1, c2, r;
    logic [7:0]         g;
    bit                 hit;
    res = '0;
    res.status = ST_OK;
    v = it.sample_value;
    case (it.cmd)
      CMD_CLEAR: map_len = 0;
      CMD_APPEND: begin
        if (map_len >= MAX_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          map_val[map_len] = it.entry_value;
          map_col[map_len] = it.entry_color;
          map_len++;
        end
      end
      CMD_CONVERT: begin
        if (map_len == 0) begin
          num = longint'(v) - longint'(ramp_lo);
          den = longint'(ramp_hi) - longint'(ramp_lo);
          if (den == 0) begin
            g = (num < 0) ? 8'd0 : GRAY_FULL;
          end else begin
            if (den < 0) begin
              num = -num;
              den = -den;
            end
            if (num <= 0) g = 8'd0;
            else if (num >= den) g = GRAY_FULL;
            else begin
              q = (num * 255) / den;
              g = q[7:0];
            end
          end
          res.pixel_color = OPAQUE_BLACK | {8'h00, g, g, g};
        end else if (map_len == 1) begin
          res.pixel_color = map_col[0];
        end else begin
          hit = 1'b0;
          for (int i = 0; i + 1 < map_len; i++) begin
            if (!hit && v >= map_val[i] && v <= map_val[i+1]) begin
              hit = 1'b1;
              num = longint'(v) - longint'(map_val[i]);
              den = longint'(map_val[i+1]) - longint'(map_val[i]);
              for (int ch = 0; ch < NUM_CH; ch++) begin
                c1 = longint'(map_col[i][8*ch +: 8]);
                c2 = longint'(map_col[i+1][8*ch +: 8]);
                if (den == 0) begin
                  r = c1;
                end else begin
                  // floor division, not truncation towards zero
                  prod = num * (c2 - c1);
                  q = prod / den;
                  if (prod % den != 0 && prod < 0) q = q - 1;
                  r = c1 + q;
                end
                res.pixel_color[8*ch +: 8] = r[7:0];
              end
            end
          end
          if (!hit) begin
            res.pixel_color = OPAQUE_BLACK;
            res.status = ST_NOMATCH;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Monitor: register writes/reads, result checks and input transfers.
  always @(posedge clk) begin
    out_item_t want, got;
    if (rst_n) begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (reg_e'(paddr[2]) == REG_RAMP_MIN) ramp_lo <= pwdata;
          else ramp_hi <= pwdata;
        end else if (prdata !== ((reg_e'(paddr[2]) == REG_RAMP_MIN) ? ramp_lo : ramp_hi)) begin
          errors++;
          $display("%0t: register read at %0h: expected %h, got %h", $time, paddr,
                   (reg_e'(paddr[2]) == REG_RAMP_MIN) ? ramp_lo : ramp_hi, prdata);
        end
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_px.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got colour %h status %0d",
                   $time, got.pixel_color, got.status);
        end else begin
          want = pending_px.pop_front();
          if (got.pixel_color !== want.pixel_color) begin
            errors++;
            $display("%0t: pixel_color mismatch: expected %h, got %h", $time,
                     want.pixel_color, got.pixel_color);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, got %0d", $time,
                     want.status, got.status);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = ramp_lookup(in_data);
        pending_px.insert(pending_px.size(), fixed_valid ? fixed_res : want);
      end
    end
  end

  function automatic in_item_t mk(logic [1:0] c, logic [31:0] sv, logic [31:0] ev,
                                  logic [31:0] ec);
    in_item_t it;
    it.cmd = c;
    it.sample_value = sv;
    it.entry_value = ev;
    it.entry_color = ec;
    return it;
  endfunction

  function automatic dir_row_t row(logic [1:0] c, logic [31:0] sv, logic [31:0] ev,
                                   logic [31:0] ec, int unsigned n, bit fx,
                                   logic [31:0] px, status_e st);
    dir_row_t d;
    d.item = mk(c, sv, ev, ec);
    d.reps = n;
    d.fixed = fx;
    d.res.pixel_color = px;
    d.res.status = st;
    return d;
  endfunction

  function automatic void tab_add(dir_row_t d);
    dir_tab.insert(dir_tab.size(), d);
  endfunction

  function automatic longint rand_between(longint a, longint b);
    longint unsigned r;
    r = {$urandom(), $urandom()};
    return a + longint'(r % longint'(b - a + 1));
  endfunction

  task automatic send_item(in_item_t it, bit fx = 1'b0, out_item_t res = '0);
    in_valid <= 1'b1;
    in_data <= it;
    fixed_valid <= fx;
    fixed_res <= res;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // only called with nothing in flight; each write is read back
  task automatic write_reg(reg_e r, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_px.size() != 0);
  endtask

  task automatic gray_burst();
    longint lo, hi, span, v;
    lo = (ramp_lo < ramp_hi) ? longint'(ramp_lo) : longint'(ramp_hi);
    hi = (ramp_lo < ramp_hi) ? longint'(ramp_hi) : longint'(ramp_lo);
    span = hi - lo;
    send_item(mk(CMD_CLEAR, $urandom, $urandom, $urandom));
    repeat ($urandom_range(2, 6)) begin
      if ($urandom_range(0, 4) == 0) v = longint'($signed($urandom));
      else v = rand_between(lo - span / 8 - 2, hi + span / 8 + 2);
      send_item(mk(CMD_CONVERT, v[31:0], $urandom, $urandom));
    end
  endtask

  // clear, a run of appends (mostly ascending), then conversions near the map
  task automatic map_sequence();
    longint      pts [$];
    longint      cur, step_max, pmin, pmax, v;
    int unsigned k, sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) k = $urandom_range(0, 1);
    else if (sel == 1) k = $urandom_range(MAX_ENTRIES, MAX_ENTRIES + 2);
    else k = $urandom_range(2, 8);
    case ($urandom_range(0, 2))
      0: step_max = 64'h100;
      1: step_max = 64'h4_0000;
      default: step_max = 64'h1000_0000;
    endcase
    cur = ($urandom_range(0, 2) == 0) ? longint'($signed($urandom))
                                      : rand_between(-64'sh10_0000, 64'sh10_0000);
    pmin = cur;
    pmax = cur;
    send_item(mk(CMD_CLEAR, $urandom, $urandom, $urandom));
    for (int i = 0; i < k; i++) begin
      if (i > 0) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) cur = cur;                        // repeated breakpoint
        else if (sel == 1) cur = cur - rand_between(1, step_max);
        else cur = cur + rand_between(1, step_max);
        cur = longint'($signed(cur[31:0]));
      end
      if (i < MAX_ENTRIES) begin
        pts.insert(pts.size(), cur);
        if (cur < pmin) pmin = cur;
        if (cur > pmax) pmax = cur;
      end
      send_item(mk(CMD_APPEND, $urandom, cur[31:0], $urandom));
    end
    repeat ($urandom_range(2, 8)) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) v = rand_between(pmin, pmax);
      else if (sel < 8 && pts.size() > 0)
        v = pts[$urandom_range(0, pts.size() - 1)] + longint'(int'($urandom_range(0, 2)) - 1);
      else v = longint'($signed($urandom));
      send_item(mk(CMD_CONVERT, v[31:0], $urandom, $urandom));
    end
  endtask

  // receiver: random ready/stall bursts, one long hold-off on request
  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [31:0] ph_min [NUM_PHASES];
    logic [31:0] ph_max [NUM_PHASES];
    int unsigned target;
    ph_min = '{RAMP_MIN_RST, 32'h0010_0000, 32'h00FF_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h0, 32'h0};
    ph_max = '{RAMP_MAX_RST, 32'h0010_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h0, 32'h0};

    // reset-state gray ramp, one-entry map, a plain segment and its edges
    tab_add(row(CMD_CONVERT, 32'h0, 32'h0, 32'h0, 1, 1, OPAQUE_BLACK, ST_OK));
    tab_add(row(CMD_CONVERT, 32'h00FF_0000, 32'h0, 32'h0, 1, 1, 32'hFFFF_FFFF, ST_OK));
    tab_add(row(CMD_CONVERT, 32'h8000_0000, 32'h0, 32'h0, 1, 1, OPAQUE_BLACK, ST_OK));
    tab_add(row(CMD_CONVERT, 32'h7FFF_FFFF, 32'h0, 32'h0, 1, 1, 32'hFFFF_FFFF, ST_OK));
    tab_add(row(CMD_CONVERT, 32'h007F_8000, 32'h0, 32'h0, 1, 0, 32'h0, ST_OK));
    tab_add(row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1,
                32'h0, ST_OK));
    tab_add(row(CMD_APPEND, 32'h0, 32'h0001_0000, 32'h1122_3344, 1, 1, 32'h0, ST_OK));
    tab_add(row(CMD_CONVERT, 32'hFFFF_FFFB, 32'h0, 32'h0, 1, 1, 32'h1122_3344, ST_OK));
    tab_add(row(CMD_APPEND, 32'h0, 32'h0005_0000, 32'hFF00_FF00, 1, 1, 32'h0, ST_OK));
    tab_add(row(CMD_CONVERT, 32'h0003_0000, 32'h0, 32'h0, 1, 0, 32'h0, ST_OK));
    tab_add(row(CMD_CONVERT, 32'h0001_0000, 32'h0, 32'h0, 1, 1, 32'h1122_3344, ST_OK));
    tab_add(row(CMD_CONVERT, 32'h0005_0000, 32'h0, 32'h0, 1, 1, 32'hFF00_FF00, ST_OK));
    tab_add(row(CMD_CONVERT, 32'h0, 32'h0, 32'h0, 1, 1, OPAQUE_BLACK, ST_NOMATCH));
    // falling segment can never match
    tab_add(row(CMD_APPEND, 32'h0, 32'h0002_0000, 32'h0, 1, 1, 32'h0, ST_OK));
    tab_add(row(CMD_CONVERT, 32'h0006_0000, 32'h0, 32'h0, 1, 1, OPAQUE_BLACK,
                ST_NOMATCH));
    // full map of equal breakpoints: zero-length segment, then a dropped append
    tab_add(row(CMD_CLEAR, 32'hFFFF_FFFF, 32'h0, 32'h0, 1, 1, 32'h0, ST_OK));
    tab_add(row(CMD_APPEND, 32'h0, 32'h7FFF_FFFF, 32'hA5A5_A5A5, MAX_ENTRIES, 1,
                32'h0, ST_OK));
    tab_add(row(CMD_APPEND, 32'h0, 32'h8000_0000, 32'h0, 1, 1, 32'h0, ST_FULL));
    tab_add(row(CMD_CONVERT, 32'h7FFF_FFFF, 32'h0, 32'h0, 1, 1, 32'hA5A5_A5A5, ST_OK));
    tab_add(row(CMD_CONVERT, 32'h8000_0000, 32'h0, 32'h0, 1, 1, OPAQUE_BLACK,
                ST_NOMATCH));
    // widest possible segment
    tab_add(row(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 1, 1, 32'h0, ST_OK));
    tab_add(row(CMD_APPEND, 32'h0, 32'h8000_0000, 32'h0, 1, 1, 32'h0, ST_OK));
    tab_add(row(CMD_APPEND, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 32'h0, ST_OK));
    tab_add(row(CMD_CONVERT, 32'h0, 32'h0, 32'h0, 1, 0, 32'h0, ST_OK));
    tab_add(row(CMD_CONVERT, 32'h8000_0000, 32'h0, 32'h0, 1, 1, 32'h0, ST_OK));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct = 30;
    foreach (dir_tab[i]) begin
      repeat (dir_tab[i].reps) send_item(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].res);
    end

    target = sent_cnt;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p >= 5) begin
        ph_min[p] = $urandom;
        ph_max[p] = $urandom;
      end
      write_reg(REG_RAMP_MIN, ph_min[p]);
      write_reg(REG_RAMP_MAX, ph_max[p]);
      @(posedge clk);
      calm = (p == NUM_PHASES - 1);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 50;
      endcase
      if (p == 1) hold_off_req = 1'b1;
      target += PHASE_ITEMS;
      while (sent_cnt < target) begin
        case ($urandom_range(0, 9))
          0: send_item(mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom));
          1, 2: gray_burst();
          default: map_sequence();
        endcase
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending_px.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
